[sv/bale_pkg.sv]
`default_nettype none

package bale_pkg;

  // List geometry.
  localparam int CAPACITY = 8;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Field widths of the request and result beats.
  localparam int OP_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int RC_W = 16;
  localparam int ST_W = 3;
  localparam int IDX_W = 6;
  localparam int ECNT_W = 7;
  localparam int IN_TDATA_W = 56;
  localparam int OUT_TDATA_W = 48;
  localparam int MODC_W = $clog2(RC_W + 1);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_W-1:0] OP_ROTATE = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP = 3'd4;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 3'd3;
  localparam logic [ST_W-1:0] ST_MISS = 3'd4;

  // Read address sources.
  typedef enum logic [2:0] {
    RD_IDX,
    RD_PREV,
    RD_NEXT,
    RD_POS,
    RD_TOP
  } rd_sel_t;

  // Write data sources; the write address is always the walk index.
  typedef enum logic [1:0] {
    WD_RDATA,
    WD_VALUE,
    WD_TMP
  } wr_data_t;

  // Walk index updates.
  typedef enum logic [2:0] {
    IX_HOLD,
    IX_POS,
    IX_ZERO,
    IX_TOP_INS,
    IX_TOP_ROT,
    IX_DEC,
    IX_INC
  } idx_op_t;

  // Entry count updates.
  typedef enum logic [1:0] {
    CN_HOLD,
    CN_INC,
    CN_DEC
  } cnt_op_t;

  // Result value and index sources.
  typedef enum logic [1:0] {
    OV_ZERO,
    OV_RDATA,
    OV_TMP
  } out_val_t;

  typedef enum logic {
    OI_ZERO,
    OI_IDX
  } out_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load_req;
    logic            rd_en;
    rd_sel_t         rd_sel;
    logic            wr_en;
    wr_data_t        wr_data;
    idx_op_t         idx_op;
    cnt_op_t         cnt_op;
    logic            tmp_load;
    logic            mod_start;
    logic            rep_load;
    logic            rep_dec;
    logic            out_load;
    logic [ST_W-1:0] out_status;
    out_val_t        out_val;
    out_idx_t        out_idx;
    logic            out_last;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            count_zero;
    logic            count_full;
    logic            pos_gt_count;
    logic            pos_ge_count;
    logic            idx_eq_pos;
    logic            idx_zero;
    logic            idx_last;
    logic            match;
    logic            mod_busy;
    logic            rep_zero;
    logic            out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[sv/bale_ctrl.sv]
`default_nettype none

module bale_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire bale_pkg::dp_stat_t  stat,
  output bale_pkg::ctl_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EMIT,
    S_SU_CHK,
    S_SU_WR,
    S_DEL_GONE,
    S_DEL_CHK,
    S_DEL_WR,
    S_SR_RD,
    S_SR_CMP,
    S_MOD,
    S_ROT_CHK,
    S_ROT_TMP,
    S_DM_RD,
    S_DM_OUT
  } state_t;

  state_t                        state, state_next;
  logic [bale_pkg::ST_W-1:0]     resp_status, resp_status_next;
  bale_pkg::out_val_t            resp_val, resp_val_next;
  bale_pkg::out_idx_t            resp_idx, resp_idx_next;
  logic                          at_bottom;

  // No request is taken while reset is held.
  assign req_ready = (state == S_IDLE) && !rst;

  // The shift-up walk stops at the insert position, or at the head for a rotate step.
  assign at_bottom = (stat.op == bale_pkg::OP_INSERT) ? stat.idx_eq_pos : stat.idx_zero;

  // Next state, command decode and the pending single-beat response.
  always_comb begin
    state_next       = state;
    resp_status_next = resp_status;
    resp_val_next    = resp_val;
    resp_idx_next    = resp_idx;
    cmd              = '0;
    cmd.rd_sel       = bale_pkg::RD_IDX;
    cmd.wr_data      = bale_pkg::WD_RDATA;
    cmd.idx_op       = bale_pkg::IX_HOLD;
    cmd.cnt_op       = bale_pkg::CN_HOLD;
    cmd.out_status   = bale_pkg::ST_OK;
    cmd.out_val      = bale_pkg::OV_ZERO;
    cmd.out_idx      = bale_pkg::OI_ZERO;
    case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.load_req = 1'b1;
          state_next   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        resp_status_next = bale_pkg::ST_OK;
        resp_val_next    = bale_pkg::OV_ZERO;
        resp_idx_next    = bale_pkg::OI_ZERO;
        state_next       = S_EMIT;
        case (stat.op)
          bale_pkg::OP_INSERT: begin
            if (stat.count_full) begin
              resp_status_next = bale_pkg::ST_FULL;
            end else if (stat.pos_gt_count) begin
              resp_status_next = bale_pkg::ST_BADPOS;
            end else begin
              cmd.idx_op = bale_pkg::IX_TOP_INS;
              state_next = S_SU_CHK;
            end
          end
          bale_pkg::OP_DELETE: begin
            if (stat.count_zero) begin
              resp_status_next = bale_pkg::ST_EMPTY;
            end else if (stat.pos_ge_count) begin
              resp_status_next = bale_pkg::ST_BADPOS;
            end else begin
              cmd.idx_op = bale_pkg::IX_POS;
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = bale_pkg::RD_POS;
              state_next = S_DEL_GONE;
            end
          end
          bale_pkg::OP_SEARCH: begin
            if (stat.count_zero) begin
              resp_status_next = bale_pkg::ST_EMPTY;
            end else begin
              cmd.idx_op = bale_pkg::IX_ZERO;
              state_next = S_SR_RD;
            end
          end
          bale_pkg::OP_ROTATE: begin
            if (stat.count_zero) begin
              resp_status_next = bale_pkg::ST_EMPTY;
            end else begin
              cmd.mod_start = 1'b1;
              state_next    = S_MOD;
            end
          end
          bale_pkg::OP_DUMP: begin
            if (stat.count_zero) begin
              resp_status_next = bale_pkg::ST_EMPTY;
            end else begin
              cmd.idx_op = bale_pkg::IX_ZERO;
              state_next = S_DM_RD;
            end
          end
          default: begin
            resp_status_next = bale_pkg::ST_OK;
          end
        endcase
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_status;
          cmd.out_val    = resp_val;
          cmd.out_idx    = resp_idx;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_SU_CHK: begin
        if (at_bottom) begin
          cmd.wr_en = 1'b1;
          if (stat.op == bale_pkg::OP_INSERT) begin
            cmd.wr_data      = bale_pkg::WD_VALUE;
            cmd.cnt_op       = bale_pkg::CN_INC;
            resp_status_next = bale_pkg::ST_OK;
            state_next       = S_EMIT;
          end else begin
            cmd.wr_data = bale_pkg::WD_TMP;
            state_next  = S_ROT_CHK;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = bale_pkg::RD_PREV;
          state_next = S_SU_WR;
        end
      end
      S_SU_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_data = bale_pkg::WD_RDATA;
        cmd.idx_op  = bale_pkg::IX_DEC;
        state_next  = S_SU_CHK;
      end
      S_DEL_GONE: begin
        cmd.tmp_load = 1'b1;
        state_next   = S_DEL_CHK;
      end
      S_DEL_CHK: begin
        if (stat.idx_last) begin
          cmd.cnt_op       = bale_pkg::CN_DEC;
          resp_status_next = bale_pkg::ST_OK;
          resp_val_next    = bale_pkg::OV_TMP;
          state_next       = S_EMIT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = bale_pkg::RD_NEXT;
          state_next = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_data = bale_pkg::WD_RDATA;
        cmd.idx_op  = bale_pkg::IX_INC;
        state_next  = S_DEL_CHK;
      end
      S_SR_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = bale_pkg::RD_IDX;
        state_next = S_SR_CMP;
      end
      S_SR_CMP: begin
        if (stat.match) begin
          resp_status_next = bale_pkg::ST_OK;
          resp_idx_next    = bale_pkg::OI_IDX;
          state_next       = S_EMIT;
        end else if (stat.idx_last) begin
          resp_status_next = bale_pkg::ST_MISS;
          state_next       = S_EMIT;
        end else begin
          cmd.idx_op = bale_pkg::IX_INC;
          state_next = S_SR_RD;
        end
      end
      S_MOD: begin
        if (!stat.mod_busy) begin
          cmd.rep_load = 1'b1;
          state_next   = S_ROT_CHK;
        end
      end
      S_ROT_CHK: begin
        if (stat.rep_zero) begin
          resp_status_next = bale_pkg::ST_OK;
          state_next       = S_EMIT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = bale_pkg::RD_TOP;
          state_next = S_ROT_TMP;
        end
      end
      S_ROT_TMP: begin
        cmd.tmp_load = 1'b1;
        cmd.idx_op   = bale_pkg::IX_TOP_ROT;
        cmd.rep_dec  = 1'b1;
        state_next   = S_SU_CHK;
      end
      S_DM_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = bale_pkg::RD_IDX;
        state_next = S_DM_OUT;
      end
      S_DM_OUT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = bale_pkg::ST_OK;
          cmd.out_val    = bale_pkg::OV_RDATA;
          cmd.out_idx    = bale_pkg::OI_IDX;
          cmd.out_last   = stat.idx_last;
          if (stat.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_op = bale_pkg::IX_INC;
            state_next = S_DM_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and the registered response selection.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      resp_status <= bale_pkg::ST_OK;
      resp_val    <= bale_pkg::OV_ZERO;
      resp_idx    <= bale_pkg::OI_ZERO;
    end else begin
      state       <= state_next;
      resp_status <= resp_status_next;
      resp_val    <= resp_val_next;
      resp_idx    <= resp_idx_next;
    end
  end

endmodule

`default_nettype wire

[sv/bale_datapath.sv]
`default_nettype none

module bale_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire bale_pkg::ctl_cmd_t            cmd,
  output bale_pkg::dp_stat_t                 stat,
  input  wire logic [bale_pkg::OP_W-1:0]     operation,
  input  wire logic signed [bale_pkg::VAL_W-1:0] value,
  input  wire logic [bale_pkg::POS_W-1:0]    position,
  input  wire logic [bale_pkg::RC_W-1:0]     rotate_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bale_pkg::ST_W-1:0]          status,
  output logic signed [bale_pkg::VAL_W-1:0]  item_value,
  output logic [bale_pkg::IDX_W-1:0]         item_index,
  output logic [bale_pkg::ECNT_W-1:0]        entry_count,
  output logic                               last
);

  localparam int AW = bale_pkg::AW;
  localparam int CW = bale_pkg::CW;

  logic [bale_pkg::OP_W-1:0]     req_op;
  logic [bale_pkg::VAL_W-1:0]    req_value;
  logic [bale_pkg::POS_W-1:0]    req_pos;
  logic [bale_pkg::RC_W-1:0]     req_rc;
  logic [CW-1:0]                 count;
  logic [AW-1:0]                 idx;
  logic [bale_pkg::VAL_W-1:0]    tmp;
  logic [bale_pkg::VAL_W-1:0]    mem [bale_pkg::CAPACITY];
  logic [bale_pkg::VAL_W-1:0]    rdata;
  logic [AW-1:0]                 rd_addr;
  logic [bale_pkg::VAL_W-1:0]    wdata;
  logic [CW-1:0]                 mod_rem;
  logic [bale_pkg::RC_W-1:0]     mod_bits;
  logic [bale_pkg::MODC_W-1:0]   mod_cnt;
  logic [CW:0]                   mod_shift;
  logic [CW-1:0]                 mod_rem_next;
  logic [CW-1:0]                 rep;

  // Request capture on the accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op    <= operation;
      req_value <= value;
      req_pos   <= position;
      req_rc    <= rotate_count;
    end
  end

  // Read address selection for the single read port.
  always_comb begin
    case (cmd.rd_sel)
      bale_pkg::RD_IDX:  rd_addr = idx;
      bale_pkg::RD_PREV: rd_addr = idx - AW'(1);
      bale_pkg::RD_NEXT: rd_addr = idx + AW'(1);
      bale_pkg::RD_POS:  rd_addr = AW'(req_pos);
      bale_pkg::RD_TOP:  rd_addr = AW'(count - CW'(1));
      default:           rd_addr = idx;
    endcase
  end

  // Write data selection; entries are always written at the walk index.
  always_comb begin
    case (cmd.wr_data)
      bale_pkg::WD_RDATA: wdata = rdata;
      bale_pkg::WD_VALUE: wdata = req_value;
      bale_pkg::WD_TMP:   wdata = tmp;
      default:            wdata = rdata;
    endcase
  end

  // Entry storage with a registered read that holds between reads.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[idx] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Walk index and the held entry used by delete and rotate.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      case (cmd.idx_op)
        bale_pkg::IX_HOLD:    idx <= idx;
        bale_pkg::IX_POS:     idx <= AW'(req_pos);
        bale_pkg::IX_ZERO:    idx <= '0;
        bale_pkg::IX_TOP_INS: idx <= AW'(count);
        bale_pkg::IX_TOP_ROT: idx <= AW'(count - CW'(1));
        bale_pkg::IX_DEC:     idx <= idx - AW'(1);
        bale_pkg::IX_INC:     idx <= idx + AW'(1);
        default:              idx <= idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tmp_load) begin
      tmp <= rdata;
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        bale_pkg::CN_HOLD: count <= count;
        bale_pkg::CN_INC:  count <= count + CW'(1);
        bale_pkg::CN_DEC:  count <= count - CW'(1);
        default:           count <= count;
      endcase
    end
  end

  // Restoring remainder of the rotate count by the entry count, one bit a cycle.
  assign mod_shift = {mod_rem, mod_bits[bale_pkg::RC_W-1]};
  assign mod_rem_next = (mod_shift >= {1'b0, count}) ? CW'(mod_shift - {1'b0, count})
                                                     : CW'(mod_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cnt <= '0;
    end else if (cmd.mod_start) begin
      mod_rem  <= '0;
      mod_bits <= req_rc;
      mod_cnt  <= bale_pkg::MODC_W'(bale_pkg::RC_W);
    end else if (mod_cnt != '0) begin
      mod_rem  <= mod_rem_next;
      mod_bits <= {mod_bits[bale_pkg::RC_W-2:0], 1'b0};
      mod_cnt  <= mod_cnt - bale_pkg::MODC_W'(1);
    end
  end

  // Remaining single-place rotate steps.
  always_ff @(posedge clk) begin
    if (cmd.rep_load) begin
      rep <= mod_rem;
    end else if (cmd.rep_dec) begin
      rep <= rep - CW'(1);
    end
  end

  // Result register; the next result can load as the current one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= cmd.out_status;
      entry_count <= bale_pkg::ECNT_W'(count);
      last        <= cmd.out_last;
      case (cmd.out_val)
        bale_pkg::OV_ZERO:  item_value <= '0;
        bale_pkg::OV_RDATA: item_value <= rdata;
        bale_pkg::OV_TMP:   item_value <= tmp;
        default:            item_value <= '0;
      endcase
      item_index <= (cmd.out_idx == bale_pkg::OI_IDX) ? bale_pkg::IDX_W'(idx) : '0;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.op           = req_op;
    stat.count_zero   = (count == '0);
    stat.count_full   = (count == CW'(bale_pkg::CAPACITY));
    stat.pos_gt_count = bale_pkg::ECNT_W'(req_pos) > bale_pkg::ECNT_W'(count);
    stat.pos_ge_count = bale_pkg::ECNT_W'(req_pos) >= bale_pkg::ECNT_W'(count);
    stat.idx_eq_pos   = bale_pkg::ECNT_W'(idx) == bale_pkg::ECNT_W'(req_pos);
    stat.idx_zero     = (idx == '0);
    stat.idx_last     = (CW'(idx) + CW'(1)) == count;
    stat.match        = (rdata == req_value);
    stat.mod_busy     = (mod_cnt != '0);
    stat.rep_zero     = (rep == '0);
    stat.out_free     = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

[sv/bounded_array_list_engine.sv]
// A rejected or unknown request answers without touching the entries. Insert shifts the
// entries from position upward by one place, delete shifts those above position down, search
// walks from the head to a match or the end, and dump gives one beat per entry; the walks
// run on one memory port. Rotate finds k = rotate_count mod count in the remainder unit, then
// makes k single-place steps. One request is in work at a time; the next is accepted the
// cycle after its last result loads. Reset (rst, synchronous, active high) empties the list
// and blocks input; entry storage is not cleared.
`default_nettype none

module bounded_array_list_engine (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // Fields from bit 0: value[31:0], position[37:32], rotate_count[53:38], zero fill.
  input  wire logic [bale_pkg::IN_TDATA_W-1:0]     s_tdata,
  // Fields from bit 0: operation[2:0].
  input  wire logic [bale_pkg::OP_W-1:0]           s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // Fields from bit 0: status[2:0], item_value[34:3], item_index[40:35], entry_count[47:41].
  output logic [bale_pkg::OUT_TDATA_W-1:0]         m_tdata,
  output logic                                     m_tlast
);

  bale_pkg::ctl_cmd_t                     cmd;
  bale_pkg::dp_stat_t                     stat;
  logic [bale_pkg::ST_W-1:0]              status;
  logic signed [bale_pkg::VAL_W-1:0]      item_value;
  logic [bale_pkg::IDX_W-1:0]             item_index;
  logic [bale_pkg::ECNT_W-1:0]            entry_count;

  // Sequencing of each request.
  bale_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage, walk index, remainder unit and result register.
  bale_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (s_tuser),
    .value        (s_tdata[31:0]),
    .position     (s_tdata[37:32]),
    .rotate_count (s_tdata[53:38]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (status),
    .item_value   (item_value),
    .item_index   (item_index),
    .entry_count  (entry_count),
    .last         (m_tlast)
  );

  // Result beat packing.
  assign m_tdata = {entry_count, item_index, item_value, status};

endmodule

`default_nettype wire

[sv/bale_checker.sv]
`default_nettype none

module bale_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [bale_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic                             m_tlast
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // Requests are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted in the cycle after an accept");

  // Only a dump gives more than one beat, and every non-final beat is ok.
  a_multi_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[2:0] == bale_pkg::ST_OK)
    else $error("non-final result beat with an error status");

  // No request is taken while a dump still has beats to give.
  a_dump_blocks: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("request accepted before a dump finished");

endmodule

bind bounded_array_list_engine bale_checker u_bale_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

[tb/sv/bounded_array_list_engine_test.sv]
`default_nettype none

module bounded_array_list_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS = 21;
  localparam logic [bale_pkg::OP_W-1:0] OP_LAST_CODE = '1;
  localparam logic [bale_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [bale_pkg::VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [bale_pkg::VAL_W-1:0] VAL_ONES = 32'hffff_ffff;
  localparam logic [bale_pkg::POS_W-1:0] POS_TOP = '1;
  localparam logic [bale_pkg::RC_W-1:0] RC_TOP = '1;

  // One result beat as the list engine reports it.
  typedef struct packed {
    logic [bale_pkg::ST_W-1:0]   status;
    logic [bale_pkg::VAL_W-1:0]  item_value;
    logic [bale_pkg::IDX_W-1:0]  item_index;
    logic [bale_pkg::ECNT_W-1:0] entry_count;
    logic                        last;
  } list_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [bale_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic [bale_pkg::OP_W-1:0]        s_tuser = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [bale_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tlast;

  // Shadow copy of the list and the results it predicts.
  logic [bale_pkg::VAL_W-1:0] list_model [bale_pkg::CAPACITY];
  int                         list_count = 0;
  list_result_t               pending_results [$];

  int mismatch_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_req = 0;
  int rx_hold_ack = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;

  bounded_array_list_engine u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Queue one expected beat; the entry count is taken after the update.
  function automatic void push_result(logic [bale_pkg::ST_W-1:0] status,
                                      logic [bale_pkg::VAL_W-1:0] value,
                                      logic [bale_pkg::IDX_W-1:0] index, logic last);
    list_result_t r;
    r.status = status;
    r.item_value = value;
    r.item_index = index;
    r.entry_count = bale_pkg::ECNT_W'(list_count);
    r.last = last;
    pending_results.push_back(r);
  endfunction

  // Apply one accepted request to the shadow list and queue its results.
  function automatic void predict_list_op(logic [bale_pkg::OP_W-1:0] op,
                                          logic [bale_pkg::VAL_W-1:0] value,
                                          logic [bale_pkg::POS_W-1:0] pos,
                                          logic [bale_pkg::RC_W-1:0] rc);
    logic [bale_pkg::VAL_W-1:0] rotated [bale_pkg::CAPACITY];
    logic [bale_pkg::VAL_W-1:0] removed;
    int i;
    int shift;
    int hit;
    hit = -1;
    case (op)
      bale_pkg::OP_INSERT: begin
        if (list_count >= bale_pkg::CAPACITY) begin
          push_result(bale_pkg::ST_FULL, '0, '0, 1'b1);
        end else if (pos > list_count) begin
          push_result(bale_pkg::ST_BADPOS, '0, '0, 1'b1);
        end else begin
          for (i = list_count; i > pos; i--) list_model[i] = list_model[i-1];
          list_model[pos] = value;
          list_count++;
          push_result(bale_pkg::ST_OK, '0, '0, 1'b1);
        end
      end
      bale_pkg::OP_DELETE: begin
        if (list_count == 0) begin
          push_result(bale_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else if (pos >= list_count) begin
          push_result(bale_pkg::ST_BADPOS, '0, '0, 1'b1);
        end else begin
          removed = list_model[pos];
          for (i = pos; i + 1 < list_count; i++) list_model[i] = list_model[i+1];
          list_count--;
          push_result(bale_pkg::ST_OK, removed, '0, 1'b1);
        end
      end
      bale_pkg::OP_SEARCH: begin
        if (list_count == 0) begin
          push_result(bale_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (i = list_count - 1; i >= 0; i--) begin
            if (list_model[i] == value) hit = i;
          end
          if (hit < 0) push_result(bale_pkg::ST_MISS, '0, '0, 1'b1);
          else push_result(bale_pkg::ST_OK, '0, bale_pkg::IDX_W'(hit), 1'b1);
        end
      end
      bale_pkg::OP_ROTATE: begin
        if (list_count == 0) begin
          push_result(bale_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          shift = int'(rc) % list_count;
          for (i = 0; i < list_count; i++) rotated[(i + shift) % list_count] = list_model[i];
          for (i = 0; i < list_count; i++) list_model[i] = rotated[i];
          push_result(bale_pkg::ST_OK, '0, '0, 1'b1);
        end
      end
      bale_pkg::OP_DUMP: begin
        if (list_count == 0) begin
          push_result(bale_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (i = 0; i < list_count; i++) begin
            push_result(bale_pkg::ST_OK, list_model[i], bale_pkg::IDX_W'(i),
                        i + 1 == list_count);
          end
        end
      end
      default: begin
        // Unused codes answer ok and leave the list alone.
        push_result(bale_pkg::ST_OK, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // Offer one request beat, wait for its accept, then idle at random.
  task automatic send_request(input logic [bale_pkg::OP_W-1:0] op,
                              input logic [bale_pkg::VAL_W-1:0] value,
                              input logic [bale_pkg::POS_W-1:0] pos,
                              input logic [bale_pkg::RC_W-1:0] rc);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {{(bale_pkg::IN_TDATA_W-bale_pkg::VAL_W-bale_pkg::POS_W-bale_pkg::RC_W){1'b0}},
                rc, pos, value};
    do @(posedge clk); while (!s_tready);
    predict_list_op(op, value, pos, rc);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Build one random request that mostly respects the current list contents.
  task automatic send_random_request();
    logic [bale_pkg::OP_W-1:0]  op;
    logic [bale_pkg::VAL_W-1:0] value;
    logic [bale_pkg::POS_W-1:0] pos;
    logic [bale_pkg::RC_W-1:0]  rc;
    int pick;
    pick = $urandom_range(0, 99);
    value = $urandom;
    case ($urandom_range(0, 9))
      0: value = VAL_MIN;
      1: value = VAL_MAX;
      2: value = VAL_ONES;
      default: ;
    endcase
    pos = bale_pkg::POS_W'($urandom_range(0, POS_TOP));
    rc = ($urandom_range(0, 9) < 7) ? bale_pkg::RC_W'($urandom_range(0, 2 * bale_pkg::CAPACITY))
                                    : bale_pkg::RC_W'($urandom_range(0, RC_TOP));
    if (pick < 38) begin
      op = bale_pkg::OP_INSERT;
      if ($urandom_range(0, 99) < 85) pos = bale_pkg::POS_W'($urandom_range(0, list_count));
    end else if (pick < 62) begin
      op = bale_pkg::OP_DELETE;
      if (list_count > 0 && $urandom_range(0, 99) < 85) begin
        pos = bale_pkg::POS_W'($urandom_range(0, list_count - 1));
      end
    end else if (pick < 76) begin
      op = bale_pkg::OP_SEARCH;
      if (list_count > 0 && $urandom_range(0, 99) < 60) begin
        value = list_model[$urandom_range(0, list_count - 1)];
      end
    end else if (pick < 86) begin
      op = bale_pkg::OP_ROTATE;
    end else if (pick < 95) begin
      op = bale_pkg::OP_DUMP;
    end else begin
      op = bale_pkg::OP_W'($urandom_range(bale_pkg::OP_DUMP + 1, OP_LAST_CODE));
    end
    send_request(op, value, pos, rc);
  endtask

  // Requests on an empty list, including an insert one past the end.
  task automatic test_empty_list();
    send_request(bale_pkg::OP_INSERT, 32'h1234_5678, 6'd1, '0);
    send_request(bale_pkg::OP_DELETE, '0, '0, '0);
    send_request(bale_pkg::OP_SEARCH, '0, '0, '0);
    send_request(bale_pkg::OP_ROTATE, '0, '0, 16'd5);
    send_request(bale_pkg::OP_DUMP, '0, '0, '0);
  endtask

  // Fill to capacity at the front, the back and the middle, then overfill.
  task automatic test_fill_to_capacity();
    send_request(bale_pkg::OP_INSERT, VAL_MIN, 6'd0, '0);
    send_request(bale_pkg::OP_INSERT, VAL_MAX, 6'd1, '0);
    send_request(bale_pkg::OP_INSERT, '0, 6'd1, '0);
    send_request(bale_pkg::OP_INSERT, VAL_ONES, 6'd0, '0);
    send_request(bale_pkg::OP_INSERT, 32'h0000_0005, 6'd4, '0);
    send_request(bale_pkg::OP_INSERT, 32'h5555_aaaa, 6'd2, '0);
    send_request(bale_pkg::OP_INSERT, 32'haaaa_5555, 6'd6, '0);
    send_request(bale_pkg::OP_INSERT, 32'h0000_0007, 6'd3, '0);
    // A full list reports full even when the position is also out of range.
    send_request(bale_pkg::OP_INSERT, 32'h0000_0009, POS_TOP, '0);
  endtask

  // Search hit and miss, rotate extremes, dump and deletes at both ends.
  task automatic test_search_rotate_delete();
    send_request(bale_pkg::OP_SEARCH, VAL_MAX, '0, '0);
    send_request(bale_pkg::OP_SEARCH, 32'h0bad_f00d, '0, '0);
    send_request(bale_pkg::OP_ROTATE, '0, '0, '0);
    send_request(bale_pkg::OP_ROTATE, '0, '0, RC_TOP);
    send_request(bale_pkg::OP_DUMP, '0, '0, '0);
    send_request(bale_pkg::OP_DELETE, '0, POS_TOP, '0);
    send_request(bale_pkg::OP_DELETE, '0, 6'd7, '0);
    send_request(bale_pkg::OP_DELETE, '0, 6'd0, '0);
    send_request(bale_pkg::OP_INSERT, 32'h0000_0001, POS_TOP, '0);
  endtask

  // Every code above the defined operations.
  task automatic test_unused_codes();
    logic [bale_pkg::OP_W-1:0] op;
    for (op = bale_pkg::OP_W'(bale_pkg::OP_DUMP + 1); op != '0; op++) begin
      send_request(op, VAL_ONES, POS_TOP, RC_TOP);
    end
  endtask

  // The receiver holds off while requests keep coming, so the input stalls.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_req++;
    repeat (12) send_random_request();
  endtask

  // One phase of random traffic with the given idle rates.
  task automatic test_random_traffic(input int tx_idle, input int rx_stall);
    tx_idle_pct = tx_idle;
    rx_stall_pct = rx_stall;
    repeat (PHASE_ITEMS) send_random_request();
  endtask

  // Receiver side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rx_hold_ack != rx_hold_req) begin
      rx_hold_ack <= rx_hold_req;
      rx_hold_left <= RX_HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin : check_results
    list_result_t got;
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[2:0];
      got.item_value = m_tdata[34:3];
      got.item_index = m_tdata[40:35];
      got.entry_count = m_tdata[47:41];
      got.last = m_tlast;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual 0x%0h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
          mismatch_count++;
        end
        if (got.item_value != want.item_value) begin
          $display("%0t: item_value expected 0x%0h, actual 0x%0h", $time,
                   want.item_value, got.item_value);
          mismatch_count++;
        end
        if (got.item_index != want.item_index) begin
          $display("%0t: item_index expected %0d, actual %0d", $time,
                   want.item_index, got.item_index);
          mismatch_count++;
        end
        if (got.entry_count != want.entry_count) begin
          $display("%0t: entry_count expected %0d, actual %0d", $time,
                   want.entry_count, got.entry_count);
          mismatch_count++;
        end
        if (got.last != want.last) begin
          $display("%0t: last expected %0d, actual %0d", $time, want.last, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 38;
    rx_stall_pct = 73;
    test_empty_list();
    test_fill_to_capacity();
    test_search_rotate_delete();
    test_unused_codes();
    test_backpressure();
    test_random_traffic(38, 73);
    test_random_traffic(73, 38);
    test_random_traffic(0, 0);
    s_tvalid <= 1'b0;

    // Let every expected beat arrive, then watch for stray ones.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/bale_pkg.sv
sv/bale_ctrl.sv
sv/bale_datapath.sv
sv/bounded_array_list_engine.sv
sv/bale_checker.sv
tb/sv/bounded_array_list_engine_test.sv
